@@ rtl/hmxs_pkg.sv @@
package hmxs_pkg;

  // Field and counter widths
  localparam int POS_W             = 11;
  localparam int PLEN_W            = 12;
  localparam int MAX_PACKET_LENGTH = 2048;
  localparam int MAX_KEY_BYTES     = 4;
  localparam int KEY_W             = 32;
  localparam int KLEN_W            = 3;
  localparam int KIDX_W            = 2;
  localparam int HOLD_DEPTH        = 7;
  localparam int HOLD_IDX_W        = 3;
  localparam int WORD_LEN_W        = 3;
  localparam int NUM_WORDS         = 9;
  localparam int WINDOW_LEN        = 10;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0]           SPACE_BYTE     = 8'h20;
  localparam logic [NUM_WORDS-1:0] ALL_CANDIDATES = '1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'd1;

  localparam logic [KEY_W-1:0]  KEY_BYTES_RESET  = 32'hA55A_AA55;
  localparam logic [KLEN_W-1:0] KEY_LENGTH_RESET = 3'd4;

  // Method words: GET POST HEAD OPTIONS PUT DELETE CONNECT TRACE PATCH
  localparam logic [WORD_LEN_W-1:0] WORD_LEN [NUM_WORDS] =
    '{3'd3, 3'd4, 3'd4, 3'd7, 3'd3, 3'd6, 3'd7, 3'd5, 3'd5};

  localparam logic [7:0] WORD_TEXT [NUM_WORDS][HOLD_DEPTH] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53},
    '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00},
    '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54},
    '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h00, 8'h00},
    '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h00, 8'h00}
  };

  typedef enum logic [1:0] {
    MODE_DECIDING = 2'd0,
    MODE_MATCHED  = 2'd1,
    MODE_PLAIN    = 2'd2
  } mode_t;

  typedef enum logic {
    FR_ACCEPT = 1'b0,
    FR_FLUSH  = 1'b1
  } front_state_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [PLEN_W-1:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       packet_end;
    logic       run_end;
  } out_item_t;

  // One classified byte handed from the front end to the back end.
  typedef struct packed {
    logic [7:0]            data;
    logic [POS_W-1:0]      pos;
    logic                  matched;
    logic [WORD_LEN_W-1:0] word_len;
    logic                  packet_end;
    logic                  run_end;
  } job_t;

  // Packet length with zero taken as one and large values saturated.
  function automatic logic [PLEN_W-1:0] eff_plen(input logic [PLEN_W-1:0] plen);
    logic [PLEN_W-1:0] r;
    r = plen;
    if (plen == '0) r = PLEN_W'(1);
    if (plen > PLEN_W'(MAX_PACKET_LENGTH)) r = PLEN_W'(MAX_PACKET_LENGTH);
    return r;
  endfunction

  // Key length with zero taken as one and large values saturated.
  function automatic logic [KLEN_W-1:0] eff_klen(input logic [KLEN_W-1:0] klen);
    logic [KLEN_W-1:0] r;
    r = klen;
    if (klen == '0) r = KLEN_W'(1);
    if (klen > KLEN_W'(MAX_KEY_BYTES)) r = KLEN_W'(MAX_KEY_BYTES);
    return r;
  endfunction

  // Position modulo three: base-4 digit sum, then a short subtract chain.
  function automatic logic [1:0] mod3(input logic [POS_W-1:0] pos);
    logic [POS_W:0] ext;
    logic [4:0]     s;
    ext = {1'b0, pos};
    s   = '0;
    for (int d = 0; d < (POS_W + 1) / 2; d++) begin
      s = s + 5'(ext[2*d +: 2]);
    end
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd6)  s = s - 5'd6;
    if (s >= 5'd3)  s = s - 5'd3;
    return s[1:0];
  endfunction

  // Key byte for an absolute byte position.
  function automatic logic [7:0] key_at(input logic [POS_W-1:0]  pos,
                                        input logic [KEY_W-1:0]  key,
                                        input logic [KLEN_W-1:0] klen);
    logic [KLEN_W-1:0] k;
    logic [KIDX_W-1:0] idx;
    k = eff_klen(klen);
    case (k)
      3'd2:    idx = {1'b0, pos[0]};
      3'd3:    idx = mod3(pos);
      3'd4:    idx = pos[1:0];
      default: idx = '0;
    endcase
    return key[8*idx +: 8];
  endfunction

endpackage

@@ rtl/hmxs_front.sv @@
module hmxs_front
  import hmxs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  in_item_t item,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  front_state_t          state, state_next;
  logic [POS_W-1:0]      pos, pos_next;
  logic [NUM_WORDS-1:0]  cand, cand_next;
  mode_t                 mode, mode_next;
  logic [WORD_LEN_W-1:0] wl, wl_next;
  logic                  flush_matched, flush_matched_next;
  logic [WORD_LEN_W-1:0] flush_wl, flush_wl_next;
  logic                  flush_last, flush_last_next;
  logic [HOLD_IDX_W-1:0] flush_top, flush_top_next;
  logic [HOLD_IDX_W-1:0] flush_idx, flush_idx_next;
  logic [7:0]            hold [HOLD_DEPTH];

  logic                  accept;
  logic [PLEN_W-1:0]     plen;
  logic [PLEN_W-1:0]     pos_plus1;
  logic                  last;
  logic                  hold_path;
  logic [NUM_WORDS-1:0]  cand_new;
  logic                  found;
  logic [WORD_LEN_W-1:0] found_len;
  logic                  flush;

  assign item_stall = (state != FR_ACCEPT) || q_full;
  assign accept     = item_valid && !item_stall;

  // Classify the incoming byte against the remaining method words.
  always_comb begin
    plen      = eff_plen(item.packet_length);
    pos_plus1 = {1'b0, pos} + PLEN_W'(1);
    last      = pos_plus1 >= plen;
    hold_path = (mode == MODE_DECIDING) && (pos < POS_W'(HOLD_DEPTH));
    for (int m = 0; m < NUM_WORDS; m++) begin
      cand_new[m] = cand[m]
        && !(plen <= PLEN_W'(WORD_LEN[m])
             || (POS_W'(WORD_LEN[m]) > pos
                 && WORD_TEXT[m][pos[HOLD_IDX_W-1:0]] != item.data_byte));
    end
    found     = 1'b0;
    found_len = '0;
    for (int m = 0; m < NUM_WORDS; m++) begin
      if (cand_new[m] && PLEN_W'(WORD_LEN[m]) == pos_plus1) begin
        found     = 1'b1;
        found_len = WORD_LEN[m];
      end
    end
    flush = found || (cand_new == '0) || last || (pos_plus1 >= PLEN_W'(HOLD_DEPTH));
  end

  // Next state, packet tracking and queue writes.
  always_comb begin
    state_next         = state;
    pos_next           = pos;
    cand_next          = cand;
    mode_next          = mode;
    wl_next            = wl;
    flush_matched_next = flush_matched;
    flush_wl_next      = flush_wl;
    flush_last_next    = flush_last;
    flush_top_next     = flush_top;
    flush_idx_next     = flush_idx;
    q_push             = 1'b0;
    q_job              = '0;
    case (state)
      FR_ACCEPT: begin
        if (accept) begin
          if (hold_path) begin
            cand_next = cand_new;
            if (found) begin
              mode_next = MODE_MATCHED;
              wl_next   = found_len;
            end else if (flush) begin
              mode_next = MODE_PLAIN;
            end
            if (flush) begin
              state_next         = FR_FLUSH;
              flush_matched_next = found;
              flush_wl_next      = found ? found_len : wl;
              flush_last_next    = last;
              flush_top_next     = pos[HOLD_IDX_W-1:0];
              flush_idx_next     = '0;
            end
          end else begin
            q_push           = 1'b1;
            q_job.data       = item.data_byte;
            q_job.pos        = pos;
            q_job.matched    = (mode == MODE_MATCHED);
            q_job.word_len   = wl;
            q_job.packet_end = last;
            q_job.run_end    = 1'b1;
            if (mode == MODE_DECIDING) mode_next = MODE_PLAIN;
          end
          // The packet's last byte restarts the method search.
          if (last) begin
            pos_next  = '0;
            cand_next = ALL_CANDIDATES;
            mode_next = MODE_DECIDING;
            wl_next   = '0;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
      end
      FR_FLUSH: begin
        if (!q_full) begin
          q_push           = 1'b1;
          q_job.data       = hold[flush_idx];
          q_job.pos        = POS_W'(flush_idx);
          q_job.matched    = flush_matched;
          q_job.word_len   = flush_wl;
          q_job.packet_end = (flush_idx == flush_top) && flush_last;
          q_job.run_end    = (flush_idx == flush_top);
          if (flush_idx == flush_top) begin
            state_next = FR_ACCEPT;
          end else begin
            flush_idx_next = flush_idx + HOLD_IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = FR_ACCEPT;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_ACCEPT;
      pos   <= '0;
      cand  <= ALL_CANDIDATES;
      mode  <= MODE_DECIDING;
      wl    <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      cand  <= cand_next;
      mode  <= mode_next;
      wl    <= wl_next;
    end
  end

  // Flush bookkeeping and the held bytes carry no reset.
  always_ff @(posedge clk) begin
    flush_matched <= flush_matched_next;
    flush_wl      <= flush_wl_next;
    flush_last    <= flush_last_next;
    flush_top     <= flush_top_next;
    flush_idx     <= flush_idx_next;
    if (accept && hold_path) begin
      hold[pos[HOLD_IDX_W-1:0]] <= item.data_byte;
    end
  end

endmodule

@@ rtl/hmxs_queue.sv @@
module hmxs_queue
  import hmxs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/hmxs_back.sv @@
module hmxs_back
  import hmxs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [KEY_W-1:0]  key_bytes,
  input  logic [KLEN_W-1:0] key_length,
  input  logic              head_valid,
  input  job_t              head_job,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result
);

  out_item_t        res_next;
  logic [7:0]       key_byte;
  logic [POS_W-1:0] win_lo;
  logic [POS_W-1:0] win_hi;
  logic             in_window;

  assign pop = head_valid && (!result_valid || !result_stall);

  // Corrupt or scramble one byte according to its packet's mode.
  always_comb begin
    key_byte  = key_at(head_job.pos, key_bytes, key_length);
    win_lo    = POS_W'(head_job.word_len);
    win_hi    = win_lo + POS_W'(WINDOW_LEN);
    in_window = (head_job.pos >= win_lo) && (head_job.pos < win_hi);
    res_next.packet_end = head_job.packet_end;
    res_next.run_end    = head_job.run_end;
    if (head_job.matched) begin
      if (head_job.pos == POS_W'(1)) begin
        res_next.result_byte = SPACE_BYTE;
      end else if (in_window) begin
        res_next.result_byte = head_job.data ^ key_byte;
      end else begin
        res_next.result_byte = head_job.data;
      end
    end else begin
      res_next.result_byte = head_job.data ^ key_byte;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res_next;
    end
  end

endmodule

@@ rtl/http_method_aware_xor_scrambler.sv @@
// HTTP-method-aware XOR scrambler.
// Input channel (item_valid, item_stall, item): one payload byte per item,
// each carrying the packet length. Output channel (result_valid,
// result_stall, result): one byte per item, with packet_end on the last
// byte of the packet and run_end on the last result caused by an input byte.
// Configuration: cfg_write with cfg_index and cfg_data writes key_bytes or
// key_length; write only while the block is idle.
// The first bytes of a packet are held until the method word is known.
// A byte past that point goes straight into the queue when it is accepted,
// then through the output register; one item per cycle is sustained while
// the output is not stalled. When the decision is made on byte p (p below
// seven), the input stalls while held bytes 0 to p are written one per cycle,
// unless the queue is full, into the two-entry queue; this sequencing in
// the front end sets the rate at the start of each packet.
// Reset (rst, synchronous) restores the default key, empties the queue and
// output register and starts a new packet. When the receiver stalls, the
// output register holds its item, the queue fills and item_stall rises.
module http_method_aware_xor_scrambler
  import hmxs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  in_item_t             item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output out_item_t            result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data
);

  logic [KEY_W-1:0]  key_bytes;
  logic [KLEN_W-1:0] key_length;
  logic              q_full;
  logic              q_push;
  job_t              q_job;
  logic              q_pop;
  logic              q_head_valid;
  job_t              q_head_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= KEY_BYTES_RESET;
      key_length <= KEY_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_BYTES:  key_bytes  <= cfg_data;
        REG_KEY_LENGTH: key_length <= cfg_data[KLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hmxs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  hmxs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  hmxs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .key_bytes    (key_bytes),
    .key_length   (key_length),
    .head_valid   (q_head_valid),
    .head_job     (q_head_job),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
